// ----- src/bsb_pkg.sv -----
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types and constants of the Bloom signature builder.
// ----------------------------------------------------------------------------
package bsb_pkg;

  localparam int unsigned WORD_BITS_DEF   = 16;
  localparam int unsigned MAX_WORDS_DEF   = 256;
  localparam int unsigned NUM_COLUMNS_DEF = 4;
  localparam int unsigned COL_SLOTS       = 4;
  localparam int unsigned Q_DEPTH         = 2;

  localparam logic [30:0] PM_M       = 31'h7fffffff;
  localparam logic [31:0] PM_SEEDMOD = 32'h7ffffffe;
  localparam logic [14:0] PM_A       = 15'd16807;

  localparam logic [8:0]  SIG_WORDS_RST = 9'd5;
  localparam logic [11:0] BITS_COL_RST  = 12'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_SIG_WORDS = 3'd0,
    REG_BITS_COL0 = 3'd1,
    REG_BITS_COL1 = 3'd2,
    REG_BITS_COL2 = 3'd3,
    REG_BITS_COL3 = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    K_NOP   = 3'd0,
    K_CLEAR = 3'd1,
    K_ADD   = 3'd2,
    K_READ  = 3'd3,
    K_RERR  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  column;
    logic [31:0] hash_value;
    logic [7:0]  word_index;
  } item_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

// ----- src/bsb_front.sv -----
// ----------------------------------------------------------------------------
// bsb_front
// Accepts input items, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module bsb_front #(
  parameter int unsigned MAX_WORDS   = bsb_pkg::MAX_WORDS_DEF,
  parameter int unsigned NUM_COLUMNS = bsb_pkg::NUM_COLUMNS_DEF,
  localparam int unsigned EW = $clog2(MAX_WORDS + 1)
) (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // column[1:0], hash_value[33:2], word_index[41:34], zero pad
  input  logic [47:0]           s_axis_tdata,
  // operation[1:0], is_null[2]
  input  logic [2:0]            s_axis_tuser,
  input  logic [EW-1:0]         eff_words_i,
  input  bsb_pkg::back_status_t status_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output bsb_pkg::item_t        item_o
);
  import bsb_pkg::*;

  localparam int unsigned IW = (EW > 8) ? EW : 8;

  logic [1:0] op;
  logic       is_null;
  logic       col_ok;
  logic       idx_ok;

  assign op      = s_axis_tuser[1:0];
  assign is_null = s_axis_tuser[2];
  assign col_ok  = {1'b0, s_axis_tdata[1:0]} < 3'(NUM_COLUMNS);
  assign idx_ok  = IW'(s_axis_tdata[41:34]) < IW'(eff_words_i);

  assign s_axis_tready = !q_full_i && !status_i.init_busy;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_o.column     = s_axis_tdata[1:0];
    item_o.hash_value = s_axis_tdata[33:2];
    item_o.word_index = s_axis_tdata[41:34];
    unique case (op)
      OP_CLEAR: item_o.kind = K_CLEAR;
      OP_ADD:   item_o.kind = (!is_null && col_ok) ? K_ADD : K_NOP;
      OP_READ:  item_o.kind = idx_ok ? K_READ : K_RERR;
      default:  item_o.kind = K_NOP;
    endcase
  end

endmodule

// ----- src/bsb_queue.sv -----
// ----------------------------------------------------------------------------
// bsb_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module bsb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bsb_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output bsb_pkg::item_t item_o
);
  import bsb_pkg::*;

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  item_t         mem_q [Q_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (PW+1)'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- src/bsb_back.sv -----
// ----------------------------------------------------------------------------
// bsb_back
// Carries out items: store sweep, generator steps, serial modulo, read and
// bit set on the signature store, and the result register.
// ----------------------------------------------------------------------------
module bsb_back #(
  parameter int unsigned WORD_BITS = bsb_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_WORDS = bsb_pkg::MAX_WORDS_DEF,
  localparam int unsigned EW = $clog2(MAX_WORDS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  bsb_pkg::item_t         item_i,
  output logic                   item_pop_o,
  input  logic [EW-1:0]          eff_words_i,
  input  logic [3:0][11:0]       bits_i,
  output bsb_pkg::back_status_t  status_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // read_data[15:0]
  output logic [15:0]            m_axis_tdata,
  // index_error[0]
  output logic [0:0]             m_axis_tuser
);
  import bsb_pkg::*;

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_FOLD  = 9'b000001000,
    S_MOD   = 9'b000010000,
    S_FETCH = 9'b000100000,
    S_WR    = 9'b001000000,
    S_RRES  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  logic           init_q, init_d;
  logic           seed_q, seed_d;
  item_t          item_q, item_d;
  logic [30:0]    gen_q, gen_d;
  logic [45:0]    prod_q, prod_d;
  logic [11:0]    cnt_q, cnt_d;
  logic [30:0]    sh_q, sh_d;
  logic [4:0]     mcnt_q, mcnt_d;
  logic [EW-1:0]  w_q, w_d;
  logic [BW-1:0]  b_q, b_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [15:0]    res_data_q, res_data_d;
  logic           res_err_q, res_err_d;
  logic           out_valid_q;
  logic [15:0]    out_data_q;
  logic           out_err_q;

  logic [WORD_BITS-1:0] mem_q [MAX_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [15:0]          rd16;

  logic        out_free;
  logic        out_load;
  logic [31:0] fsum;
  logic [30:0] fx;
  logic [31:0] sv;
  logic [31:0] sred;
  logic [BW:0] b2;
  logic [EW:0] w2;

  generate
    if (WORD_BITS >= 16) begin : g_rd_wide
      assign rd16 = rdata_q[15:0];
    end else begin : g_rd_narrow
      assign rd16 = {(16 - WORD_BITS)'(0), rdata_q};
    end
  endgenerate

  // mod 2^31-1 fold of the product
  always_comb begin
    fsum = {1'b0, prod_q[30:0]} + 32'(prod_q[45:31]);
    if (fsum >= {1'b0, PM_M}) begin
      fsum = fsum - {1'b0, PM_M};
    end
    fx = fsum[30:0];
  end

  // reseed from hash xor output
  always_comb begin
    sv = item_q.hash_value ^ {1'b0, fx - 31'd1};
    priority if (sv >= {PM_SEEDMOD[30:0], 1'b0}) begin
      sred = sv - {PM_SEEDMOD[30:0], 1'b0};
    end else if (sv >= PM_SEEDMOD) begin
      sred = sv - PM_SEEDMOD;
    end else begin
      sred = sv;
    end
  end

  // one remainder bit a step, kept as word and bit
  always_comb begin
    b2 = {b_q, sh_q[30]};
    w2 = {w_q, 1'b0};
    if (b2 >= (BW+1)'(WORD_BITS)) begin
      b2 = b2 - (BW+1)'(WORD_BITS);
      w2 = w2 + 1'b1;
    end
    if (w2 >= {1'b0, eff_words_i}) begin
      w2 = w2 - {1'b0, eff_words_i};
    end
  end

  assign out_free   = !out_valid_q || m_axis_tready;
  assign out_load   = (state_q == S_DONE) && out_free;
  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;
  assign status_o.init_busy = init_q;

  always_comb begin
    state_d    = state_q;
    init_d     = init_q;
    seed_d     = seed_q;
    item_d     = item_q;
    gen_d      = gen_q;
    prod_d     = prod_q;
    cnt_d      = cnt_q;
    sh_d       = sh_q;
    mcnt_d     = mcnt_q;
    w_d        = w_q;
    b_d        = b_q;
    clr_d      = clr_q;
    res_data_d = res_data_q;
    res_err_d  = res_err_q;
    mem_we     = 1'b0;
    mem_waddr  = w_q[AW-1:0];
    mem_wdata  = rdata_q | (WORD_BITS'(1) << b_q);
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(MAX_WORDS - 1)) begin
          clr_d   = '0;
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          item_d     = item_i;
          res_data_d = '0;
          res_err_d  = 1'b0;
          unique case (item_i.kind)
            K_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            K_ADD: begin
              gen_d   = 31'(item_i.column) + 31'd1;
              cnt_d   = bits_i[item_i.column];
              seed_d  = 1'b1;
              state_d = S_MUL;
            end
            K_READ: begin
              w_d     = EW'(item_i.word_index);
              state_d = S_FETCH;
            end
            K_RERR: begin
              res_err_d = 1'b1;
              state_d   = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_MUL: begin
        prod_d  = gen_q * PM_A;
        state_d = S_FOLD;
      end
      S_FOLD: begin
        if (seed_q) begin
          gen_d   = sred[30:0] + 31'd1;
          seed_d  = 1'b0;
          state_d = (cnt_q == '0) ? S_DONE : S_MUL;
        end else begin
          gen_d   = fx;
          sh_d    = fx - 31'd1;
          w_d     = '0;
          b_d     = '0;
          mcnt_d  = '0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        b_d    = b2[BW-1:0];
        w_d    = w2[EW-1:0];
        sh_d   = {sh_q[29:0], 1'b0};
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == 5'd30) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = (item_q.kind == K_ADD) ? S_WR : S_RRES;
      end
      S_WR: begin
        mem_we  = 1'b1;
        cnt_d   = cnt_q - 1'b1;
        state_d = (cnt_d == '0) ? S_DONE : S_MUL;
      end
      S_RRES: begin
        res_data_d = rd16;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      init_q      <= 1'b1;
      seed_q      <= 1'b0;
      gen_q       <= 31'd1;
      cnt_q       <= '0;
      mcnt_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      seed_q  <= seed_d;
      gen_q   <= gen_d;
      cnt_q   <= cnt_d;
      mcnt_q  <= mcnt_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    prod_q     <= prod_d;
    sh_q       <= sh_d;
    w_q        <= w_d;
    b_q        <= b_d;
    res_data_q <= res_data_d;
    res_err_q  <= res_err_d;
    if (out_load) begin
      out_data_q <= res_data_q;
      out_err_q  <= res_err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[w_q[AW-1:0]];
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_err_q;

  a_gen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != '0 && gen_q != PM_M)
    else $error("generator state out of range");

  a_mod_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> {1'b0, w_q} < {1'b0, eff_words_i})
    else $error("word index not below signature length");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_DONE)
    else $error("result raised outside done state");

endmodule

// ----- src/bloom_signature_builder.sv -----
// ----------------------------------------------------------------------------
// bloom_signature_builder
// Bloom signature of one row, built from column hashes with a minimal
// standard generator, with an APB register port and item streams.
// ----------------------------------------------------------------------------
// Every item gives one result. A read fetches one word of the store, and a
// clear sweeps the store to zero one word a cycle. An add runs, per bit, the
// generator multiply and fold, the serial modulo (one output bit a cycle) and
// a read-modify-write of the store. After reset the store is swept to zero,
// during which no item is accepted.
// Up to two items wait in a queue in front of the execution unit.
// ----------------------------------------------------------------------------
module bloom_signature_builder #(
  parameter int unsigned WORD_BITS   = bsb_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_WORDS   = bsb_pkg::MAX_WORDS_DEF,
  parameter int unsigned NUM_COLUMNS = bsb_pkg::NUM_COLUMNS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // column[1:0], hash_value[33:2], word_index[41:34], zero pad
  input  logic [47:0] s_axis_tdata,
  // operation[1:0], is_null[2]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[15:0]
  output logic [15:0] m_axis_tdata,
  // index_error[0]
  output logic [0:0]  m_axis_tuser
);
  import bsb_pkg::*;

  localparam int unsigned EW = $clog2(MAX_WORDS + 1);
  localparam int unsigned CW = (EW > 9) ? EW : 9;

  logic [8:0]       sig_words_q;
  logic [3:0][11:0] bits_q;
  logic [EW-1:0]    eff_words;
  logic [CW-1:0]    sw_ext;
  logic             wr_en;
  reg_idx_e         idx;

  back_status_t status;
  item_t        push_item, pop_item;
  logic         push, pop, q_full, q_valid;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_words_q <= SIG_WORDS_RST;
      bits_q      <= {COL_SLOTS{BITS_COL_RST}};
    end else if (wr_en) begin
      unique case (idx)
        REG_SIG_WORDS: sig_words_q <= pwdata[8:0];
        REG_BITS_COL0: bits_q[0]   <= pwdata[11:0];
        REG_BITS_COL1: bits_q[1]   <= pwdata[11:0];
        REG_BITS_COL2: bits_q[2]   <= pwdata[11:0];
        REG_BITS_COL3: bits_q[3]   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIG_WORDS: prdata = {23'd0, sig_words_q};
      REG_BITS_COL0: prdata = {20'd0, bits_q[0]};
      REG_BITS_COL1: prdata = {20'd0, bits_q[1]};
      REG_BITS_COL2: prdata = {20'd0, bits_q[2]};
      REG_BITS_COL3: prdata = {20'd0, bits_q[3]};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    sw_ext = CW'(sig_words_q);
    priority if (sw_ext == '0) begin
      eff_words = EW'(1);
    end else if (sw_ext > CW'(MAX_WORDS)) begin
      eff_words = EW'(MAX_WORDS);
    end else begin
      eff_words = sw_ext[EW-1:0];
    end
  end

  bsb_front #(
    .MAX_WORDS   (MAX_WORDS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .eff_words_i   (eff_words),
    .status_i      (status),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  bsb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  bsb_back #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_i        (pop_item),
    .item_pop_o    (pop),
    .eff_words_i   (eff_words),
    .bits_i        (bits_q),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
